[rtl/kqt_pkg.sv]
// kqt_pkg: shared types and constants for the keyed quantity table.
// Holds field widths, the entry record, operation codes and sequencer states.
// No dependencies.
`default_nettype none

package kqt_pkg;

	localparam int KEY_W     = 32;
	localparam int QTY_W     = 31;
	localparam int AMT_W     = 32;
	localparam int CNT_OUT_W = 9;

	localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

	// operation codes of an input item
	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// one stored table slot, also the word kept in the table memory
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [QTY_W-1:0] qty;
	} entry_t;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINAL  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

[rtl/kqt_ram.sv]
// kqt_ram: generic single-write, single-read memory with registered read data.
// Width and depth come from parameters; no dependencies.
`default_nettype none

module kqt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/kqt_rank.sv]
// kqt_rank: shared ranking compare of the table tracker.
// Decides whether a candidate entry beats the running best; uses kqt_pkg.
`default_nettype none

module kqt_rank (
	input  wire kqt_pkg::entry_t cand,
	input  wire kqt_pkg::entry_t inc,
	output      logic            take
);

	logic qty_gt;
	logic qty_eq;
	logic key_lt;

	// larger quantity wins, smaller key breaks a tie
	assign qty_gt = cand.qty > inc.qty;
	assign qty_eq = cand.qty == inc.qty;
	assign key_lt = cand.key < inc.key;
	assign take   = !inc.valid || qty_gt || (qty_eq && key_lt);

endmodule

`default_nettype wire

[rtl/keyed_quantity_table_max_tracker.sv]
// keyed_quantity_table_max_tracker: keyed quantity table with running maximum.
// Items are taken only when idle: each walks every slot through the table
// memory's single read port, and no new item is taken until its result is
// registered. After reset a clearing pass writes every slot before the
// first item is taken. Depends on kqt_pkg, kqt_ram and kqt_rank.
`default_nettype none

module keyed_quantity_table_max_tracker #(
	parameter int ENTRIES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        operation,
	input  wire logic [31:0] item_key,
	input  wire logic [31:0] amount,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        key_found,
	output      logic        table_full,
	output      logic        max_valid,
	output      logic [31:0] max_key,
	output      logic [30:0] max_quantity,
	output      logic [8:0]  entry_count
);

	localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int OCW   = kqt_pkg::CNT_OUT_W;
	localparam int KW    = kqt_pkg::KEY_W;
	localparam int QW    = kqt_pkg::QTY_W;
	localparam int MW    = kqt_pkg::AMT_W;
	localparam int EW    = $bits(kqt_pkg::entry_t);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	kqt_pkg::state_t state_q;

	logic [AW-1:0]    addr_q;
	logic             issued_q;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [AW-1:0]    idx_s1;
	logic [CNT_W-1:0] cnt_q;

	kqt_pkg::op_t     op_q;
	logic [KW-1:0]    key_q;
	logic [MW-1:0]    amt_q;

	logic             found_q;
	logic [AW-1:0]    found_idx_q;
	logic [QW-1:0]    found_qty_q;
	logic             free_q;
	logic [AW-1:0]    free_idx_q;
	logic             exbest_vld_q;
	logic [KW-1:0]    exbest_key_q;
	logic [QW-1:0]    exbest_qty_q;
	logic [QW-1:0]    new_qty_q;

	logic             out_valid_q;
	logic             key_found_q;
	logic             table_full_q;
	logic             max_valid_q;
	logic [KW-1:0]    max_key_q;
	logic [QW-1:0]    max_qty_q;
	logic [OCW-1:0]   count_out_q;

	logic [EW-1:0]    rd_data;
	kqt_pkg::entry_t  rd_ent;
	kqt_pkg::entry_t  new_ent;
	kqt_pkg::entry_t  inc_ent;
	kqt_pkg::entry_t  cand_ent;
	logic             take;
	logic             hit;
	logic             has_new;
	logic             full;
	logic             drop_found;
	logic             fire;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic             ram_re;
	logic [MW:0]      sum;
	logic [QW-1:0]    clamp_qty;
	logic [CNT_W-1:0] cnt_next;

	// entry records around the shared compare
	assign rd_ent       = kqt_pkg::entry_t'(rd_data);
	assign new_ent      = '{valid: 1'b1, key: key_q, qty: new_qty_q};
	assign inc_ent      = '{valid: exbest_vld_q, key: exbest_key_q, qty: exbest_qty_q};
	assign cand_ent     = (state_q == kqt_pkg::ST_SCAN) ? rd_ent : new_ent;

	kqt_rank u_rank (
		.cand (cand_ent),
		.inc  (inc_ent),
		.take (take)
	);

	// decode of the item outcome
	assign hit        = rd_vld_s1 && rd_ent.valid && (rd_ent.key == key_q);
	assign has_new    = (op_q == kqt_pkg::OP_UPDATE) && (found_q || free_q);
	assign full       = (op_q == kqt_pkg::OP_UPDATE) && !found_q && !free_q;
	assign drop_found = (op_q == kqt_pkg::OP_REMOVE) && found_q;
	assign fire       = (state_q == kqt_pkg::ST_FINAL) && (!out_valid_q || out_ready);

	// add the signed amount to the old quantity, then floor and saturate
	assign sum = $signed({2'b00, (found_q ? found_qty_q : {QW{1'b0}})})
		+ $signed({amt_q[MW-1], amt_q});
	always_comb begin
		if (sum[MW]) begin
			clamp_qty = '0;
		end else if (sum[MW-1]) begin
			clamp_qty = kqt_pkg::QTY_MAX;
		end else begin
			clamp_qty = sum[QW-1:0];
		end
	end

	// count after this item
	always_comb begin
		cnt_next = cnt_q;
		if (has_new && !found_q) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (drop_found) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
	end

	// table memory ports
	assign ram_re    = (state_q == kqt_pkg::ST_SCAN) && !issued_q;
	assign ram_we    = (state_q == kqt_pkg::ST_CLEAR) || (fire && (has_new || drop_found));
	assign ram_waddr = (state_q == kqt_pkg::ST_CLEAR) ? addr_q
		: (found_q ? found_idx_q : free_idx_q);
	assign ram_wdata = ((state_q == kqt_pkg::ST_CLEAR) || drop_found) ? {EW{1'b0}}
		: EW'(new_ent);

	kqt_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// sequencer and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kqt_pkg::ST_CLEAR;
			addr_q       <= '0;
			issued_q     <= 1'b0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			exbest_vld_q <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			unique case (state_q)
				kqt_pkg::ST_CLEAR: begin
					if (addr_q == LAST) begin
						addr_q  <= '0;
						state_q <= kqt_pkg::ST_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				kqt_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q      <= kqt_pkg::ST_SCAN;
						addr_q       <= '0;
						issued_q     <= 1'b0;
						found_q      <= 1'b0;
						free_q       <= 1'b0;
						exbest_vld_q <= 1'b0;
					end
				end
				kqt_pkg::ST_SCAN: begin
					if (!issued_q) begin
						addr_q <= addr_q + AW'(1);
						if (addr_q == LAST) begin
							issued_q <= 1'b1;
						end
					end
					if (hit) begin
						found_q <= 1'b1;
					end else if (rd_vld_s1 && rd_ent.valid && take) begin
						exbest_vld_q <= 1'b1;
					end
					if (rd_vld_s1 && !rd_ent.valid) begin
						free_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_last_s1) begin
						state_q <= kqt_pkg::ST_UPDATE;
					end
				end
				kqt_pkg::ST_UPDATE: begin
					state_q <= kqt_pkg::ST_FINAL;
				end
				kqt_pkg::ST_FINAL: begin
					if (fire) begin
						state_q <= kqt_pkg::ST_IDLE;
						cnt_q   <= cnt_next;
					end
				end
				default: begin
					state_q <= kqt_pkg::ST_CLEAR;
					addr_q  <= '0;
				end
			endcase
			// hold the result until taken
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item fields, scan results and the result record
	always_ff @(posedge clk) begin
		idx_s1     <= addr_q;
		rd_last_s1 <= (addr_q == LAST);
		if ((state_q == kqt_pkg::ST_IDLE) && in_valid) begin
			op_q  <= kqt_pkg::op_t'(operation);
			key_q <= item_key;
			amt_q <= amount;
		end
		if (state_q == kqt_pkg::ST_SCAN) begin
			if (hit) begin
				found_idx_q <= idx_s1;
				found_qty_q <= rd_ent.qty;
			end else if (rd_vld_s1 && rd_ent.valid && take) begin
				exbest_key_q <= rd_ent.key;
				exbest_qty_q <= rd_ent.qty;
			end
			if (rd_vld_s1 && !rd_ent.valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == kqt_pkg::ST_UPDATE) begin
			new_qty_q <= clamp_qty;
		end
		if (fire) begin
			key_found_q  <= found_q;
			table_full_q <= full;
			count_out_q  <= OCW'(cnt_next);
			if (has_new && take) begin
				max_valid_q <= 1'b1;
				max_key_q   <= key_q;
				max_qty_q   <= new_qty_q;
			end else if (exbest_vld_q) begin
				max_valid_q <= 1'b1;
				max_key_q   <= exbest_key_q;
				max_qty_q   <= exbest_qty_q;
			end else begin
				max_valid_q <= 1'b0;
				max_key_q   <= '0;
				max_qty_q   <= '0;
			end
		end
	end

	assign in_ready     = (state_q == kqt_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign key_found    = key_found_q;
	assign table_full   = table_full_q;
	assign max_valid    = max_valid_q;
	assign max_key      = max_key_q;
	assign max_quantity = max_qty_q;
	assign entry_count  = count_out_q;

	// a pending result agrees with the held count
	a_max_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (max_valid_q == (cnt_q != '0)))
		else $error("max_valid disagrees with entry count");

	// a dropped key means the table really is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && table_full_q) |-> (cnt_q == CNT_W'(ENTRIES)))
		else $error("table_full with free slots");

	// a key is either found or dropped, never both
	a_found_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(key_found_q && table_full_q))
		else $error("key_found and table_full together");

	// the count never runs past the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count exceeds table size");

endmodule

`default_nettype wire

[test/keyed_quantity_table_max_tracker_tb.sv]
// Testbench for keyed_quantity_table_max_tracker: directed and random update/remove items,
// checked against a built-in model of the table and its running maximum.
// Depends on kqt_pkg and the RTL of the block only.
`default_nettype none

module keyed_quantity_table_max_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TABLE_SLOTS = 256;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned HOLD_AT     = 400;
	localparam int unsigned HOLD_CYCLES = 3000;
	localparam int unsigned RX_CALM_LO  = 1200;
	localparam int unsigned RX_CALM_HI  = 1500;

	typedef struct {
		kqt_pkg::op_t op;
		logic [31:0]  key;
		logic [31:0]  amt;
		bit           calm;
	} stock_item_t;

	typedef struct {
		bit          key_found;
		bit          table_full;
		bit          max_valid;
		logic [31:0] max_key;
		logic [30:0] max_quantity;
		logic [8:0]  entry_count;
	} stock_report_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        operation    = 1'b0;
	logic [31:0] item_key     = '0;
	logic [31:0] amount       = '0;
	logic        out_ready    = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        key_found;
	logic        table_full;
	logic        max_valid;
	logic [31:0] max_key;
	logic [30:0] max_quantity;
	logic [8:0]  entry_count;

	stock_item_t   pending_items[$];
	stock_report_t expected_reports[$];
	int unsigned   mismatches   = 0;
	int unsigned   results_seen = 0;
	int unsigned   hold_left    = 0;
	bit            hold_done    = 1'b0;
	int unsigned   tx_wait      = 0;
	int unsigned   rx_wait      = 0;
	int unsigned   cycle_count  = 0;

	// model of the stock table
	bit          stock_valid[TABLE_SLOTS];
	logic [31:0] stock_key[TABLE_SLOTS];
	logic [30:0] stock_qty[TABLE_SLOTS];
	int unsigned top_slot  = 0;
	bit          top_valid = 1'b0;
	int unsigned held      = 0;

	keyed_quantity_table_max_tracker #(
		.ENTRIES(TABLE_SLOTS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.item_key    (item_key),
		.amount      (amount),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_found   (key_found),
		.table_full  (table_full),
		.max_valid   (max_valid),
		.max_key     (max_key),
		.max_quantity(max_quantity),
		.entry_count (entry_count)
	);

	always #4 clk = ~clk;

	// true if slot a ranks above slot b: larger quantity, then smaller key
	function automatic bit outranks(int unsigned a, int unsigned b);
		if (stock_qty[a] != stock_qty[b])
			return stock_qty[a] > stock_qty[b];
		return stock_key[a] < stock_key[b];
	endfunction

	function automatic void rescan_top();
		top_valid = 1'b0;
		top_slot  = 0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (stock_valid[i] && (!top_valid || outranks(i, top_slot))) begin
				top_valid = 1'b1;
				top_slot  = i;
			end
		end
	endfunction

	function automatic void offer_top(int unsigned slot);
		if (!top_valid || outranks(slot, top_slot)) begin
			top_valid = 1'b1;
			top_slot  = slot;
		end
	endfunction

	function automatic logic [30:0] clamp_qty(longint v);
		if (v < 0)
			return '0;
		if (v > 64'sh7FFF_FFFF)
			return kqt_pkg::QTY_MAX;
		return v[30:0];
	endfunction

	// apply one accepted item to the model and queue the report it yields
	function automatic void predict_stock(kqt_pkg::op_t op, logic [31:0] key,
		logic [31:0] amt);
		stock_report_t r;
		bit            hit;
		bit            room;
		int unsigned   slot;
		longint        delta;
		longint        sum;
		hit   = 1'b0;
		room  = 1'b0;
		slot  = 0;
		delta = longint'($signed(amt));
		r.table_full = 1'b0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (!hit && stock_valid[i] && stock_key[i] == key) begin
				hit  = 1'b1;
				slot = i;
			end
		end
		if (op == kqt_pkg::OP_UPDATE) begin
			if (hit) begin
				sum = longint'(stock_qty[slot]);
				sum = sum + delta;
				stock_qty[slot] = clamp_qty(sum);
				if (top_valid && top_slot == slot && delta < 0)
					rescan_top();
				else
					offer_top(slot);
			end else begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (!room && !stock_valid[i]) begin
						room = 1'b1;
						slot = i;
					end
				end
				if (!room) begin
					r.table_full = 1'b1;
				end else begin
					stock_valid[slot] = 1'b1;
					stock_key[slot]   = key;
					stock_qty[slot]   = clamp_qty(delta);
					held++;
					offer_top(slot);
				end
			end
		end else if (hit) begin
			stock_valid[slot] = 1'b0;
			held--;
			if (top_valid && top_slot == slot)
				rescan_top();
		end
		r.key_found    = hit;
		r.max_valid    = top_valid;
		r.max_key      = top_valid ? stock_key[top_slot] : '0;
		r.max_quantity = top_valid ? stock_qty[top_slot] : '0;
		r.entry_count  = held[8:0];
		expected_reports.push_back(r);
	endfunction

	function automatic int unsigned draw_wait();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// mix of extremes, small values for ties and full-range values
	function automatic logic [31:0] draw_amount();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			3, 4, 5: return 32'($signed($urandom_range(0, 16)) - 8);
			6, 7: return 32'($urandom_range(0, 3));
			8: return $urandom >> 1;
			default: return $urandom | 32'h8000_0000;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch on %s at result %0d: got %h, expected %h",
			what, results_seen, got, want);
	endtask

	task automatic queue_item(kqt_pkg::op_t op, logic [31:0] key, logic [31:0] amt,
		bit calm);
		stock_item_t it;
		it.op   = op;
		it.key  = key;
		it.amt  = amt;
		it.calm = calm;
		pending_items.push_back(it);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
	endtask

	// driver: present the next pending item, hold it until accepted
	always @(posedge clk or negedge arst_n) begin : item_driver
		stock_item_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= 1'b0;
			item_key  <= '0;
			amount    <= '0;
			tx_wait   <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				predict_stock(kqt_pkg::op_t'(operation), item_key, amount);
			if (tx_wait != 0) begin
				tx_wait  <= tx_wait - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				operation <= nxt.op;
				item_key  <= nxt.key;
				amount    <= nxt.amt;
				in_valid  <= 1'b1;
				tx_wait   <= nxt.calm ? 0 : draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, so the block stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: compare each accepted result with the oldest expected report
	always @(posedge clk or negedge arst_n) begin : result_monitor
		stock_report_t want;
		int unsigned   gap;
		if (!arst_n) begin
			out_ready    <= 1'b0;
			rx_wait      <= 0;
			results_seen <= 0;
		end else if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_reports.size() == 0) begin
				report_mismatch("result with no item pending", 0, 0);
			end else begin
				want = expected_reports.pop_front();
				if (key_found !== want.key_found)
					report_mismatch("key_found", 32'(key_found), 32'(want.key_found));
				if (table_full !== want.table_full)
					report_mismatch("table_full", 32'(table_full), 32'(want.table_full));
				if (max_valid !== want.max_valid)
					report_mismatch("max_valid", 32'(max_valid), 32'(want.max_valid));
				if (max_key !== want.max_key)
					report_mismatch("max_key", max_key, want.max_key);
				if (max_quantity !== want.max_quantity)
					report_mismatch("max_quantity", 32'(max_quantity),
						32'(want.max_quantity));
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", 32'(entry_count),
						32'(want.entry_count));
			end
			if (results_seen >= RX_CALM_LO && results_seen < RX_CALM_HI)
				gap = 0;
			else
				gap = draw_wait();
			rx_wait   <= gap;
			out_ready <= (gap == 0) && (hold_left == 0);
		end else if (rx_wait != 0) begin
			rx_wait   <= rx_wait - 1;
			out_ready <= (rx_wait == 1) && (hold_left == 0);
		end else begin
			out_ready <= (hold_left == 0);
		end
	end

	// end the run if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0]  small_keys[12];
		logic [31:0]  big_keys[300];
		logic [31:0]  k;
		kqt_pkg::op_t op;
		small_keys[0] = 32'h0000_0000;
		small_keys[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 12; i++)
			small_keys[i] = $urandom;
		for (int i = 0; i < 300; i++)
			big_keys[i] = $urandom;

		// directed: empty remove, saturation, ties, floor, rescans, absent remove
		queue_item(kqt_pkg::OP_REMOVE, 32'h0000_0005, 32'h0000_0000, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h0000_0000, 32'h0000_0001, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h0000_0007, 32'h8000_0000, 1'b1);
		queue_item(kqt_pkg::OP_UPDATE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
		queue_item(kqt_pkg::OP_REMOVE, 32'h0000_0000, 32'h1234_5678, 1'b0);
		queue_item(kqt_pkg::OP_REMOVE, 32'h0001_2345, 32'h0000_0000, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h5555_5555, 32'h5555_5555, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h5555_5555, 32'h5555_5555, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h5555_5555, 32'h0000_0000, 1'b0);
		queue_item(kqt_pkg::OP_REMOVE, 32'h0000_0007, 32'h0000_0000, 1'b0);
		queue_item(kqt_pkg::OP_REMOVE, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0);
		queue_item(kqt_pkg::OP_REMOVE, 32'h5555_5555, 32'h0000_0000, 1'b0);
		queue_item(kqt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		queue_item(kqt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		queue_item(kqt_pkg::OP_UPDATE, 32'h0000_0003, 32'h0000_0000, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// pause the sender until every directed result is back
		wait_drained();

		// small key pool: ties, saturation, max reductions and removals
		for (int i = 0; i < 600; i++) begin
			op = ($urandom_range(0, 99) < 70) ? kqt_pkg::OP_UPDATE : kqt_pkg::OP_REMOVE;
			queue_item(op, small_keys[$urandom_range(0, 11)], draw_amount(), i < 150);
		end
		// fill the table past its capacity
		for (int i = 0; i < 280; i++)
			queue_item(kqt_pkg::OP_UPDATE, big_keys[i], draw_amount(), 1'b0);
		// churn around the full table
		for (int i = 0; i < 60; i++) begin
			op = $urandom_range(0, 1) ? kqt_pkg::OP_UPDATE : kqt_pkg::OP_REMOVE;
			k  = $urandom_range(0, 4) == 0 ? $urandom : big_keys[$urandom_range(0, 299)];
			queue_item(op, k, draw_amount(), 1'b0);
		end
		// drain it again
		for (int i = 0; i < 300; i++)
			queue_item(kqt_pkg::OP_REMOVE, big_keys[i], $urandom, 1'b0);
		// mixed pools
		for (int i = 0; i < 760; i++) begin
			op = ($urandom_range(0, 99) < 60) ? kqt_pkg::OP_UPDATE : kqt_pkg::OP_REMOVE;
			case ($urandom_range(0, 3))
				0: k = small_keys[$urandom_range(0, 3)];
				1: k = small_keys[$urandom_range(0, 11)];
				2: k = big_keys[$urandom_range(0, 63)];
				default: k = big_keys[$urandom_range(0, 299)];
			endcase
			queue_item(op, k, draw_amount(), 1'b0);
		end

		wait_drained();
		repeat (TABLE_SLOTS + 8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/kqt_pkg.sv
rtl/kqt_ram.sv
rtl/kqt_rank.sv
rtl/keyed_quantity_table_max_tracker.sv
test/keyed_quantity_table_max_tracker_tb.sv
